// File: rtl/yuyv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_pkg
// Shared constants and types for the YUYV 4:2:2 to RGB888 converter.
// ----------------------------------------------------------------------------
package yuyv_pkg;

    localparam int unsigned CH_W  = 8;    // one color byte
    localparam int unsigned SUM_W = 26;   // signed Q.16 channel sum, black offset removed
    localparam int unsigned SCL_W = 17;   // (t * 255) >> 16 for t >= 0
    localparam int unsigned REC_W = 17;   // reciprocal of 219
    localparam int unsigned REC_SHIFT = 24;

    // chroma weights, scaled by 65536
    localparam logic signed [SUM_W-1:0] COEF_RV = 26'sd91881;
    localparam logic signed [SUM_W-1:0] COEF_GV = 26'sd46802;
    localparam logic signed [SUM_W-1:0] COEF_GU = 26'sd22554;
    localparam logic signed [SUM_W-1:0] COEF_BU = 26'sd116130;

    localparam logic signed [SUM_W-1:0] BLACK_Q16   = 26'sd1048576;  // 16 << 16
    localparam logic signed [8:0]       CHROMA_ZERO = 9'sd128;

    // ceil(2^24 / 219); exact floor division for w < 2^24 / 155
    localparam logic [REC_W-1:0] RECIP_219 = 17'd76609;
    // w at or above 256 * 219 saturates to white
    localparam logic [SCL_W-1:0] SAT_LIMIT = 17'd56064;

    localparam logic [CH_W-1:0] WHITE = 8'hFF;
    localparam logic [CH_W-1:0] BLACK = 8'h00;

    // load enables of the three back stages of a channel
    typedef struct packed {
        logic scale;
        logic divide;
        logic clamp;
    } stage_en_t;

endpackage

// File: rtl/yuyv_expand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_expand
// Three-stage range expansion of one channel: floor((t * 255) / (219 << 16)),
// clamped to 0..255, where t is the Q.16 sum with the black level removed.
// ----------------------------------------------------------------------------
module yuyv_expand (
    input  logic                                aclk,
    input  yuyv_pkg::stage_en_t                 en,
    input  logic signed [yuyv_pkg::SUM_W-1:0]   sum,
    output logic        [yuyv_pkg::CH_W-1:0]    chan
);

    localparam int unsigned MAG_W = yuyv_pkg::SUM_W - 1;
    localparam int unsigned MUL_W = MAG_W + 8;
    localparam int unsigned PRD_W = yuyv_pkg::SCL_W + yuyv_pkg::REC_W;

    logic [yuyv_pkg::SCL_W-1:0] scaled_reg, scaled_next;
    logic                       low_reg;
    logic [yuyv_pkg::CH_W-1:0]  quot_reg;
    logic                       sat_reg;
    logic                       low2_reg;
    logic [yuyv_pkg::CH_W-1:0]  chan_reg, chan_next;

    logic [MAG_W-1:0] mag;
    logic [MUL_W-1:0] mul255;
    logic [PRD_W-1:0] prod;

    // t * 255 as (t << 8) - t
    always_comb begin
        mag         = sum[MAG_W-1:0];
        mul255      = {mag, 8'b0} - MUL_W'(mag);
        scaled_next = mul255[MUL_W-1 -: yuyv_pkg::SCL_W];
    end

    assign prod = PRD_W'(scaled_reg) * PRD_W'(yuyv_pkg::RECIP_219);

    always_comb begin
        if (low2_reg) begin
            chan_next = yuyv_pkg::BLACK;
        end else if (sat_reg) begin
            chan_next = yuyv_pkg::WHITE;
        end else begin
            chan_next = quot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.scale) begin
            scaled_reg <= scaled_next;
            low_reg    <= sum[yuyv_pkg::SUM_W-1];
        end
        if (en.divide) begin
            quot_reg <= prod[yuyv_pkg::REC_SHIFT +: yuyv_pkg::CH_W];
            sat_reg  <= (scaled_reg >= yuyv_pkg::SAT_LIMIT);
            low2_reg <= low_reg;
        end
        if (en.clamp) begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

// File: rtl/yuyv_to_rgb_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter
// Converts one YUYV 4:2:2 macropixel into two RGB888 pixels sharing chroma.
// ----------------------------------------------------------------------------
// An input transaction passes through five register stages (chroma products,
// channel sums, scale, divide, clamp) before it appears on m_tvalid.
// Throughput: one macropixel per cycle while m_tready is high; each stage has
// its own valid bit and loads whenever it is empty or its successor moves.
// Reset: aresetn (synchronous, active low) clears the valid bits only; data
// registers are not reset.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] luma_first, [15:8] chroma_blue, [23:16] luma_second, [31:24] chroma_red
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,      // frame_end_in
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] red_first, [15:8] green_first, [23:16] blue_first,
    // [31:24] red_second, [39:32] green_second, [47:40] blue_second
    output logic [47:0] m_tdata,
    output logic        m_tlast       // frame_end_out
);

    localparam int unsigned SW = yuyv_pkg::SUM_W;
    localparam int unsigned NS = 5;

    logic [NS-1:0] vld_reg, vld_next;
    logic [NS-1:0] rdy;
    logic [NS-1:0] last_reg;

    // stage 1: chroma products
    logic [7:0]           y0_reg, y1_reg;
    logic signed [SW-1:0] rv_reg, gv_reg, gu_reg, bu_reg;
    logic signed [SW-1:0] u_ext, v_ext;
    logic signed [8:0]    u9, v9;

    // stage 2: per-channel sums
    logic signed [SW-1:0] base0, base1;
    logic signed [SW-1:0] t_reg [6];

    yuyv_pkg::stage_en_t en;
    logic [yuyv_pkg::CH_W-1:0] chan [6];

    // per-stage ready; the last stage frees when the transaction leaves
    always_comb begin
        rdy[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        vld_next[0] = rdy[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < NS; i++) begin
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    assign s_tready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_comb begin
        u9    = $signed({1'b0, s_tdata[15:8]}) - yuyv_pkg::CHROMA_ZERO;
        v9    = $signed({1'b0, s_tdata[31:24]}) - yuyv_pkg::CHROMA_ZERO;
        u_ext = SW'(u9);
        v_ext = SW'(v9);
        base0 = $signed({2'b00, y0_reg, 16'b0}) - yuyv_pkg::BLACK_Q16;
        base1 = $signed({2'b00, y1_reg, 16'b0}) - yuyv_pkg::BLACK_Q16;
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            y0_reg      <= s_tdata[7:0];
            y1_reg      <= s_tdata[23:16];
            rv_reg      <= v_ext * yuyv_pkg::COEF_RV;
            gv_reg      <= v_ext * yuyv_pkg::COEF_GV;
            gu_reg      <= u_ext * yuyv_pkg::COEF_GU;
            bu_reg      <= u_ext * yuyv_pkg::COEF_BU;
            last_reg[0] <= s_tlast;
        end
        if (rdy[1]) begin
            t_reg[0]    <= base0 + rv_reg;
            t_reg[1]    <= base0 - gv_reg - gu_reg;
            t_reg[2]    <= base0 + bu_reg;
            t_reg[3]    <= base1 + rv_reg;
            t_reg[4]    <= base1 - gv_reg - gu_reg;
            t_reg[5]    <= base1 + bu_reg;
            last_reg[1] <= last_reg[0];
        end
        for (int i = 2; i < NS; i++) begin
            if (rdy[i]) begin
                last_reg[i] <= last_reg[i-1];
            end
        end
    end

    assign en = '{scale: rdy[2], divide: rdy[3], clamp: rdy[4]};

    for (genvar c = 0; c < 6; c++) begin : g_chan
        yuyv_expand u_expand (
            .aclk (aclk),
            .en   (en),
            .sum  (t_reg[c]),
            .chan (chan[c])
        );
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tlast  = last_reg[NS-1];
    assign m_tdata  = {chan[5], chan[4], chan[3], chan[2], chan[1], chan[0]};

endmodule
